[design/mha_pkg.sv]
// constants, types and arctangent table for the magnetometer heading block
`timescale 1ns / 1ps

package mha_pkg;

  localparam int SAMPLE_W = 12;
  localparam int COORD_W = 28;
  localparam int ANGLE_W = 25;
  localparam int WRAP_W = 23;
  localparam int HEADING_W = 15;
  localparam int SCALE_SH = 12;

  localparam int CORDIC_STEPS = 16;
  localparam int TABLE_LEN = 24;
  localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [WRAP_W-1:0] wrap_t;
  typedef logic [HEADING_W-1:0] heading_t;

  // 1/16384 degree units
  localparam angle_t ANGLE_FULL = 25'sd5898240;
  localparam angle_t ANGLE_HALF = 25'sd2949120;
  localparam wrap_t ROUND_HALF = 23'd128;
  localparam int ROUND_SH = 8;
  localparam heading_t HEADING_FULL = 15'd23040;

  // atan(2^-i) in degrees times 16384
  localparam angle_t ATAN_TAB [TABLE_LEN] = '{
    25'sd737280, 25'sd435242, 25'sd229970, 25'sd116736,
    25'sd58595,  25'sd29326,  25'sd14667,  25'sd7334,
    25'sd3667,   25'sd1833,   25'sd917,    25'sd458,
    25'sd229,    25'sd115,    25'sd57,     25'sd29,
    25'sd14,     25'sd7,      25'sd4,      25'sd2,
    25'sd1,      25'sd0,      25'sd0,      25'sd0
  };

endpackage

[design/magnetometer_heading_atan2_top.sv]
// compass heading from x/y magnetometer samples by a pipelined cordic atan2
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// in        in         in_valid / in_stall   mag_x, mag_y (signed 12 bit)
// out       out        out_valid / out_stall heading (0..23039, 1/64 degree)
// cfg       in         cfg_valid / cfg_ready cfg_data (sensor_present)
//
// one item per cycle while the output is not stalled; the stages are the prep
// stage, one stage per cordic iteration, the wrap stage and the output register
// rst is synchronous active high: clears valid bits, sensor_present and
// the stored heading
// a stalled output freezes the whole pipeline in place; in_stall is high
// exactly while the output holds an item that is being stalled
// cfg_ready is always high

module magnetometer_heading_atan2_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [11:0]         mag_x,
  input  logic signed [11:0]         mag_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [14:0]                heading,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data
);

  localparam int N = mha_pkg::STEPS;

  // pipeline advance: everything moves unless a finished item is held
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  // configuration register
  logic sensor_present;
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      sensor_present <= cfg_data;
    end
  end

  // stage k holds the vector after k iterations
  mha_pkg::coord_t px [0:N];
  mha_pkg::coord_t py [0:N];
  mha_pkg::angle_t pz [0:N];
  logic            pv [0:N];
  logic            pzero [0:N];
  logic            ppres [0:N];

  // prep: scale by 2^12, turn left half plane by 180 degrees
  mha_pkg::coord_t x_scaled, y_scaled;
  assign x_scaled = {{(mha_pkg::COORD_W - mha_pkg::SAMPLE_W - mha_pkg::SCALE_SH){mag_x[11]}},
                     mag_x, {mha_pkg::SCALE_SH{1'b0}}};
  assign y_scaled = {{(mha_pkg::COORD_W - mha_pkg::SAMPLE_W - mha_pkg::SCALE_SH){mag_y[11]}},
                     mag_y, {mha_pkg::SCALE_SH{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      pv[0] <= 1'b0;
    end else if (en) begin
      pv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pzero[0] <= (mag_x == '0) && (mag_y == '0);
      ppres[0] <= sensor_present;
      if (mag_x[11]) begin
        px[0] <= -x_scaled;
        py[0] <= -y_scaled;
        pz[0] <= mha_pkg::ANGLE_HALF;
      end else begin
        px[0] <= x_scaled;
        py[0] <= y_scaled;
        pz[0] <= '0;
      end
    end
  end

  // one cordic vectoring iteration per stage
  for (genvar i = 0; i < N; i++) begin : g_iter
    mha_pkg::coord_t dx, dy;
    assign dx = py[i] >>> i;
    assign dy = px[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        pv[i+1] <= 1'b0;
      end else if (en) begin
        pv[i+1] <= pv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pzero[i+1] <= pzero[i];
        ppres[i+1] <= ppres[i];
        if (py[i] > 0) begin
          px[i+1] <= px[i] + dx;
          py[i+1] <= py[i] - dy;
          pz[i+1] <= pz[i] + mha_pkg::ATAN_TAB[i];
        end else begin
          px[i+1] <= px[i] - dx;
          py[i+1] <= py[i] + dy;
          pz[i+1] <= pz[i] - mha_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  // wrap into one turn
  mha_pkg::angle_t z_fix;
  always_comb begin
    z_fix = pz[N];
    if (pz[N] < 0) begin
      z_fix = pz[N] + mha_pkg::ANGLE_FULL;
    end else if (pz[N] >= mha_pkg::ANGLE_FULL) begin
      z_fix = pz[N] - mha_pkg::ANGLE_FULL;
    end
  end

  logic          wv, wzero, wpres;
  mha_pkg::wrap_t wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= 1'b0;
    end else if (en) begin
      wv <= pv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wz    <= z_fix[mha_pkg::WRAP_W-1:0];
      wzero <= pzero[N];
      wpres <= ppres[N];
    end
  end

  // round to 1/64 degree, fold a full turn back to north; a zero vector gives north
  mha_pkg::wrap_t   z_round;
  mha_pkg::heading_t h_raw, h_calc;
  assign z_round = wz + mha_pkg::ROUND_HALF;
  assign h_raw = z_round[mha_pkg::ROUND_SH +: mha_pkg::HEADING_W];
  always_comb begin
    if (wzero) begin
      h_calc = '0;
    end else if (h_raw >= mha_pkg::HEADING_FULL) begin
      h_calc = h_raw - mha_pkg::HEADING_FULL;
    end else begin
      h_calc = h_raw;
    end
  end

  // output register and stored heading
  mha_pkg::heading_t last_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      last_heading <= '0;
    end else if (en) begin
      out_valid <= wv;
      if (wv && wpres) begin
        last_heading <= h_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading <= wpres ? h_calc : last_heading;
    end
  end

`ifndef NO_ASSERTIONS
  // results always lie inside one turn
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading < mha_pkg::HEADING_FULL)
    else $error("heading out of range");

  a_last_range: assert property (@(posedge clk) disable iff (rst)
    last_heading < mha_pkg::HEADING_FULL)
    else $error("stored heading out of range");

  // an item leaving the wrap stage reaches the output register
  a_wrap_to_out: assert property (@(posedge clk) disable iff (rst)
    en && wv |=> out_valid)
    else $error("item lost between wrap stage and output");

  // a frozen item shows the stored heading
  a_frozen: assert property (@(posedge clk) disable iff (rst)
    en && wv && !wpres |=> heading == $past(last_heading))
    else $error("frozen item does not show stored heading");
`endif

endmodule
